@@ hw/rtl/clex_pkg.sv @@
package clex_pkg;

    localparam int OffsetWidthDefault = 32;
    localparam int LineWidthDefault   = 20;
    localparam int ColumnWidthDefault = 16;
    localparam int FifoDepth          = 4;

    localparam logic [4:0] K_NEWLINE = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_INT     = 5'd2;
    localparam logic [4:0] K_FLOAT   = 5'd3;
    localparam logic [4:0] K_STRING  = 5'd4;
    localparam logic [4:0] K_CHAR    = 5'd5;
    localparam logic [4:0] K_OP      = 5'd6;
    localparam logic [4:0] K_LPAREN  = 5'd7;
    localparam logic [4:0] K_RPAREN  = 5'd8;
    localparam logic [4:0] K_LBRACE  = 5'd9;
    localparam logic [4:0] K_RBRACE  = 5'd10;
    localparam logic [4:0] K_LBRACK  = 5'd11;
    localparam logic [4:0] K_RBRACK  = 5'd12;
    localparam logic [4:0] K_COMMA   = 5'd13;
    localparam logic [4:0] K_SEMI    = 5'd14;
    localparam logic [4:0] K_COLON   = 5'd15;
    localparam logic [4:0] K_QUEST   = 5'd16;
    localparam logic [4:0] K_DOT     = 5'd17;
    localparam logic [4:0] K_INVALID = 5'd18;
    localparam logic [4:0] K_END     = 5'd19;
    localparam logic [4:0] K_DIAG    = 5'd20;
    localparam logic [4:0] K_NONE    = 5'd31;

    localparam logic [1:0] D_NONE    = 2'd0;
    localparam logic [1:0] D_BYTE    = 2'd1;
    localparam logic [1:0] D_COMMENT = 2'd2;
    localparam logic [1:0] D_LITERAL = 2'd3;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [4:0] {
        M_IDLE, M_CR, M_OP1, M_OP2, M_SLASH, M_LCMT, M_BCMT, M_BSTAR, M_BCR,
        M_IDENT, M_ZERO, M_DEC, M_FRAC, M_EXPS, M_EXPD, M_HEX, M_OCT, M_BIN,
        M_SUFFIX, M_STR, M_STRESC, M_CHR, M_CHRESC
    } mode_t;

    typedef struct packed {
        logic        last;
        logic [15:0] len;
        logic [31:0] soff;
        logic [15:0] ecol;
        logic [19:0] eline;
        logic [15:0] scol;
        logic [19:0] sline;
        logic [1:0]  diag;
        logic [4:0]  kind;
    } res_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_xdigit(input logic [7:0] b);
        return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic is_nl(input logic [7:0] b);
        return b == 8'h0d || b == 8'h0a;
    endfunction

    function automatic logic is_op_prefix(input logic [7:0] b);
        return b == "+" || b == "-" || b == "*" || b == "%" || b == "<" || b == ">" ||
               b == "!" || b == "&" || b == "|" || b == "^" || b == "=";
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            ",":     k = K_COMMA;
            ";":     k = K_SEMI;
            ":":     k = K_COLON;
            "?":     k = K_QUEST;
            ".":     k = K_DOT;
            "~":     k = K_OP;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [19:0] clamp20(input logic [63:0] v);
        return (v > 64'hFFFFF) ? 20'hFFFFF : v[19:0];
    endfunction

    function automatic logic [15:0] clamp16(input logic [63:0] v);
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [31:0] clamp32(input logic [63:0] v);
        return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
    endfunction

endpackage

@@ hw/rtl/c_like_token_lexer.sv @@
// channel | dir | handshake        | payload
// s       | in  | s_tvalid/tready  | tdata: byte_req; tuser: op
// m       | out | m_tvalid/tready  | tdata: positions and length; tuser: kind, diag; tlast
// one source byte per clock: a held input item is lexed and written into a 4-entry
// result queue, which takes it while the queue holds at most two results
// an item gives up to two results; the queue drain rate of one per cycle while m_tready
// is high sets the long-run rate when many items give two
// rst_n clears mode, counters and queue; a stalled m side backs up into s_tready
module c_like_token_lexer
    import clex_pkg::*;
#(
    parameter int OFFSET_WIDTH = OffsetWidthDefault,
    parameter int LINE_WIDTH   = LineWidthDefault,
    parameter int COLUMN_WIDTH = ColumnWidthDefault
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // byte_req
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // start_line, start_column, end_line, end_column,
                                    // start_offset, lexeme_length
    output logic [6:0]   m_tuser,   // token_kind, diag_code
    output logic         m_tlast
);

    localparam logic [LINE_WIDTH-1:0]   LineOne = LINE_WIDTH'(1);
    localparam logic [COLUMN_WIDTH-1:0] ColOne  = COLUMN_WIDTH'(1);

    logic                    in_valid_reg;
    logic                    in_op_reg;
    logic [7:0]              in_byte_reg;
    mode_t                   mode_reg, mode_next;
    logic [7:0]              held_reg, held_next;
    logic                    flt_reg, flt_next;
    logic [LINE_WIDTH-1:0]   line_reg, line_next;
    logic [COLUMN_WIDTH-1:0] col_reg, col_next;
    logic [OFFSET_WIDTH-1:0] off_reg, off_next;
    logic [LINE_WIDTH-1:0]   tsl_reg, tsl_next;
    logic [COLUMN_WIDTH-1:0] tsc_reg, tsc_next;
    logic [OFFSET_WIDTH-1:0] tso_reg, tso_next;

    res_t       fifo_reg [FifoDepth];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    logic                    proc, pop, cont;
    logic [7:0]              b;
    logic [LINE_WIDTH-1:0]   pline;
    logic [COLUMN_WIDTH-1:0] pcol;
    logic [OFFSET_WIDTH-1:0] poff;
    logic                    e1v, e1post, e2v, e2post;
    logic [4:0]              e1k, e2k;
    logic [1:0]              e1d, e2d;
    res_t                    r1, r2;
    logic                    num_mode, stay;
    mode_t                   em;

    function automatic res_t make_res(
        input logic [4:0]              kind,
        input logic [1:0]              diag,
        input logic [LINE_WIDTH-1:0]   sl,
        input logic [COLUMN_WIDTH-1:0] sc,
        input logic [OFFSET_WIDTH-1:0] so,
        input logic [LINE_WIDTH-1:0]   el,
        input logic [COLUMN_WIDTH-1:0] ec,
        input logic [OFFSET_WIDTH-1:0] eo
    );
        res_t r;
        logic [OFFSET_WIDTH-1:0] d;
        d = (eo >= so) ? eo - so : '0;
        r.kind  = kind;
        r.diag  = diag;
        r.sline = clamp20(64'(sl));
        r.scol  = clamp16(64'(sc));
        r.eline = clamp20(64'(el));
        r.ecol  = clamp16(64'(ec));
        r.soff  = clamp32(64'(so));
        r.len   = (kind == K_NEWLINE) ? 16'd1 : clamp16(64'(d));
        r.last  = 1'b0;
        return r;
    endfunction

    assign pop      = m_tvalid && m_tready;
    assign proc     = in_valid_reg && (count_reg <= 3'd2);
    assign s_tready = !in_valid_reg || proc;
    assign b        = in_byte_reg;

    assign m_tvalid = count_reg != 3'd0;
    assign m_tuser  = {fifo_reg[rd_ptr_reg].diag, fifo_reg[rd_ptr_reg].kind};
    assign m_tlast  = fifo_reg[rd_ptr_reg].last;
    assign m_tdata  = {fifo_reg[rd_ptr_reg].len, fifo_reg[rd_ptr_reg].soff,
                       fifo_reg[rd_ptr_reg].ecol, fifo_reg[rd_ptr_reg].eline,
                       fifo_reg[rd_ptr_reg].scol, fifo_reg[rd_ptr_reg].sline};

    // position after this byte
    always_comb
    begin
        pline = line_reg;
        pcol  = col_reg;
        poff  = (&off_reg) ? off_reg : off_reg + OFFSET_WIDTH'(1);
        if (b == 8'h0a && (mode_reg == M_CR || mode_reg == M_BCR))
        begin
            pline = line_reg;
        end
        else if (is_nl(b))
        begin
            pline = (&line_reg) ? line_reg : line_reg + LineOne;
            pcol  = ColOne;
        end
        else
        begin
            pcol = (&col_reg) ? col_reg : col_reg + ColOne;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        flt_next  = flt_reg;
        line_next = line_reg;
        col_next  = col_reg;
        off_next  = off_reg;
        tsl_next  = tsl_reg;
        tsc_next  = tsc_reg;
        tso_next  = tso_reg;
        e1v = 1'b0; e1k = K_NONE; e1d = D_NONE; e1post = 1'b0;
        e2v = 1'b0; e2k = K_NONE; e2d = D_NONE; e2post = 1'b0;
        cont = 1'b0;
        stay = 1'b0;
        num_mode = 1'b0;
        em = mode_reg;
        if (in_op_reg == OP_END)
        begin
            case (mode_reg)
                M_SLASH, M_OP1, M_OP2:
                begin
                    e1v = 1'b1; e1k = K_OP;
                end
                M_BCMT, M_BSTAR, M_BCR:
                begin
                    e1v = 1'b1; e1k = K_DIAG; e1d = D_COMMENT;
                end
                M_IDENT:
                begin
                    e1v = 1'b1; e1k = K_IDENT;
                end
                M_ZERO, M_DEC, M_FRAC, M_EXPS, M_EXPD, M_HEX, M_OCT, M_BIN, M_SUFFIX:
                begin
                    e1v = 1'b1; e1k = flt_reg ? K_FLOAT : K_INT;
                end
                M_STR, M_STRESC, M_CHR, M_CHRESC:
                begin
                    e1v = 1'b1; e1k = K_INVALID; e1d = D_LITERAL;
                end
                default:
                begin
                    e1v = 1'b0;
                end
            endcase
            e2v = 1'b1; e2k = K_END;
            mode_next = M_IDLE; held_next = '0; flt_next = 1'b0;
            line_next = LineOne; col_next = ColOne; off_next = '0;
            tsl_next  = LineOne; tsc_next = ColOne; tso_next = '0;
        end
        else
        begin
            line_next = pline;
            col_next  = pcol;
            off_next  = poff;
            // effective mode for states that fall through to another
            if (mode_reg == M_ZERO && !(b inside {"x", "X", "o", "O", "b", "B"}))
                em = M_DEC;
            else if ((mode_reg == M_BSTAR && b != "/" && b != "*") ||
                     (mode_reg == M_BCR && b != 8'h0a))
                em = M_BCMT;
            num_mode = em inside {M_DEC, M_FRAC, M_EXPS, M_EXPD, M_HEX, M_OCT, M_BIN,
                                  M_SUFFIX};
            case (em)
                M_IDLE: cont = 1'b1;
                M_CR:
                begin
                    if (b == 8'h0a) mode_next = M_IDLE;
                    else cont = 1'b1;
                end
                M_SLASH:
                begin
                    if (b == "/") mode_next = M_LCMT;
                    else if (b == "*") mode_next = M_BCMT;
                    else if (b == "=")
                    begin
                        e1v = 1'b1; e1k = K_OP; e1post = 1'b1; mode_next = M_IDLE;
                    end
                    else
                    begin
                        e1v = 1'b1; e1k = K_OP; cont = 1'b1;
                    end
                end
                M_OP1:
                begin
                    if (b == held_reg && (b == "<" || b == ">"))
                    begin
                        mode_next = M_OP2;
                    end
                    else if (b == "=" || (b == held_reg && (b == "+" || b == "-" ||
                             b == "&" || b == "|")) || (held_reg == "-" && b == ">"))
                    begin
                        e1v = 1'b1; e1k = K_OP; e1post = 1'b1;
                        mode_next = M_IDLE; held_next = '0;
                    end
                    else
                    begin
                        e1v = 1'b1; e1k = K_OP; cont = 1'b1;
                    end
                end
                M_OP2:
                begin
                    e1v = 1'b1; e1k = K_OP;
                    if (b == "=")
                    begin
                        e1post = 1'b1; mode_next = M_IDLE; held_next = '0;
                    end
                    else cont = 1'b1;
                end
                M_LCMT:
                begin
                    if (is_nl(b)) cont = 1'b1;
                end
                M_BCMT:
                begin
                    if (b == "*") mode_next = M_BSTAR;
                    else if (b == 8'h0d) mode_next = M_BCR;
                    else mode_next = M_BCMT;
                end
                M_BSTAR:
                begin
                    if (b == "/") mode_next = M_IDLE;
                end
                M_BCR:
                begin
                    mode_next = M_BCMT;
                end
                M_IDENT:
                begin
                    if (!(is_alpha(b) || is_digit(b) || b == "_"))
                    begin
                        e1v = 1'b1; e1k = K_IDENT; cont = 1'b1;
                    end
                end
                M_ZERO:
                begin
                    if (b == "x" || b == "X") mode_next = M_HEX;
                    else if (b == "o" || b == "O") mode_next = M_OCT;
                    else mode_next = M_BIN;
                end
                M_STR, M_CHR:
                begin
                    if (b == "\\")
                    begin
                        mode_next = (em == M_STR) ? M_STRESC : M_CHRESC;
                    end
                    else if (b == ((em == M_STR) ? 8'h22 : 8'h27))
                    begin
                        e1v = 1'b1; e1k = (em == M_STR) ? K_STRING : K_CHAR;
                        e1post = 1'b1; mode_next = M_IDLE;
                    end
                    else if (is_nl(b))
                    begin
                        e1v = 1'b1; e1k = K_INVALID; e1d = D_LITERAL; cont = 1'b1;
                    end
                end
                M_STRESC, M_CHRESC:
                begin
                    if (is_nl(b))
                    begin
                        e1v = 1'b1; e1k = K_INVALID; e1d = D_LITERAL; cont = 1'b1;
                    end
                    else mode_next = (em == M_STRESC) ? M_STR : M_CHR;
                end
                default:
                begin
                    if (num_mode)
                    begin
                        if (em == M_DEC || em == M_FRAC || em == M_EXPD)
                            stay = is_digit(b) || b == "_";
                        else if (em == M_HEX)
                            stay = is_xdigit(b) || b == "_";
                        else if (em == M_OCT)
                            stay = (b >= "0" && b <= "7") || b == "_";
                        else if (em == M_BIN)
                            stay = b == "0" || b == "1" || b == "_";
                        if (stay)
                            mode_next = em;
                        else if (em == M_DEC && b == ".")
                        begin
                            mode_next = M_FRAC; flt_next = 1'b1;
                        end
                        else if ((em == M_DEC || em == M_FRAC) && (b == "e" || b == "E"))
                        begin
                            mode_next = M_EXPS; flt_next = 1'b1;
                        end
                        else if (em == M_EXPS && (b == "+" || b == "-" || is_digit(b) ||
                                 b == "_"))
                            mode_next = M_EXPD;
                        else if (is_alpha(b))
                        begin
                            mode_next = M_SUFFIX;
                            if (b == "f" || b == "F") flt_next = 1'b1;
                        end
                        else
                        begin
                            e1v = 1'b1; e1k = flt_reg ? K_FLOAT : K_INT; cont = 1'b1;
                        end
                    end
                    else cont = 1'b1;
                end
            endcase
            if (cont)
            begin
                mode_next = M_IDLE; held_next = '0; flt_next = 1'b0;
                if (!(b == " " || b == 8'h09 || b == 8'h0c || b == 8'h0b))
                begin
                    tsl_next = line_reg; tsc_next = col_reg; tso_next = off_reg;
                    if (is_nl(b))
                    begin
                        e2v = 1'b1; e2k = K_NEWLINE; e2post = 1'b1;
                        if (b == 8'h0d) mode_next = M_CR;
                    end
                    else if (is_alpha(b) || b == "_") mode_next = M_IDENT;
                    else if (b == "0") mode_next = M_ZERO;
                    else if (is_digit(b)) mode_next = M_DEC;
                    else if (b == 8'h22) mode_next = M_STR;
                    else if (b == 8'h27) mode_next = M_CHR;
                    else if (b == "/") mode_next = M_SLASH;
                    else if (is_op_prefix(b))
                    begin
                        mode_next = M_OP1; held_next = b;
                    end
                    else if (punct_kind(b) != K_NONE)
                    begin
                        e2v = 1'b1; e2k = punct_kind(b); e2post = 1'b1;
                    end
                    else
                    begin
                        e2v = 1'b1; e2k = K_INVALID; e2d = D_BYTE; e2post = 1'b1;
                    end
                end
            end
        end
        r1 = make_res(e1k, e1d, tsl_reg, tsc_reg, tso_reg,
                      e1post ? pline : line_reg, e1post ? pcol : col_reg,
                      e1post ? poff : off_reg);
        r2 = make_res(e2k, e2d, line_reg, col_reg, off_reg,
                      e2post ? pline : line_reg, e2post ? pcol : col_reg,
                      e2post ? poff : off_reg);
        r1.last = !e2v;
        r2.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= M_IDLE;
            held_reg     <= '0;
            flt_reg      <= 1'b0;
            line_reg     <= LineOne;
            col_reg      <= ColOne;
            off_reg      <= '0;
            tsl_reg      <= LineOne;
            tsc_reg      <= ColOne;
            tso_reg      <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (proc)
                in_valid_reg <= 1'b0;
            if (proc)
            begin
                mode_reg <= mode_next;
                held_reg <= held_next;
                flt_reg  <= flt_next;
                line_reg <= line_next;
                col_reg  <= col_next;
                off_reg  <= off_next;
                tsl_reg  <= tsl_next;
                tsc_reg  <= tsc_next;
                tso_reg  <= tso_next;
            end
            wr_ptr_reg <= wr_ptr_reg + (proc ? 2'(e1v) + 2'(e2v) : 2'd0);
            rd_ptr_reg <= rd_ptr_reg + 2'(pop);
            count_reg  <= count_reg + (proc ? 3'(e1v) + 3'(e2v) : 3'd0) - 3'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (proc && e1v)
            fifo_reg[wr_ptr_reg] <= r1;
        if (proc && e2v)
            fifo_reg[wr_ptr_reg + 2'(e1v)] <= r2;
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(FifoDepth))
        else $error("result queue overflow");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_op_reg == OP_END |=> mode_reg == M_IDLE && off_reg == '0 &&
        line_reg == LineOne)
        else $error("end item did not reset lexer");

    a_end_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_op_reg == OP_END |-> e2v && r2.kind == K_END)
        else $error("end item without end token");

    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_op_reg == OP_BYTE && !(&off_reg) |=> off_reg == $past(off_reg) +
        OFFSET_WIDTH'(1))
        else $error("offset did not advance");
`endif

endmodule

@@ tb/c_like_token_lexer_checker.sv @@
`timescale 1ns / 1ps

module c_like_token_lexer_checker
    import clex_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,
    input  logic [6:0]   m_tuser,
    input  logic         m_tlast,
    output int           errors,
    output int           pending,
    output int           tokens_seen
);

    mode_t       mode;
    logic [15:0] held;
    logic [1:0]  held_n;
    logic [3:0]  num_flags;
    logic [19:0] cur_line, tok_line, pre_line, post_line;
    logic [15:0] cur_col, tok_col, pre_col, post_col;
    logic [31:0] cur_off, tok_off, pre_off, post_off;
    int          step_results;
    res_t        token_q[$];

    function automatic bit alpha_b(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic bit digit_b(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic bit hex_b(logic [7:0] b);
        return digit_b(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic bit eol_b(logic [7:0] b);
        return b == 8'h0d || b == 8'h0a;
    endfunction

    function automatic bit opchar_b(logic [7:0] b);
        return b == "+" || b == "-" || b == "*" || b == "%" || b == "<" || b == ">" ||
               b == "!" || b == "&" || b == "|" || b == "^" || b == "=";
    endfunction

    function automatic logic [4:0] mark_kind(logic [7:0] b);
        case (b)
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            "[": return K_LBRACK;
            "]": return K_RBRACK;
            ",": return K_COMMA;
            ";": return K_SEMI;
            ":": return K_COLON;
            "?": return K_QUEST;
            ".": return K_DOT;
            "~": return K_OP;
            default: return K_NONE;
        endcase
    endfunction

    function automatic int pair_kind(logic [7:0] c, logic [7:0] b);
        if (b == "=") return 2;
        if (b == c && (c == "+" || c == "-" || c == "&" || c == "|")) return 2;
        if (b == c && (c == "<" || c == ">")) return 1;
        if (c == "-" && b == ">") return 2;
        return 0;
    endfunction

    task automatic clear_state();
        mode = M_IDLE;
        held = '0;
        held_n = '0;
        num_flags = '0;
    endtask

    task automatic mark_start();
        tok_line = pre_line;
        tok_col = pre_col;
        tok_off = pre_off;
    endtask

    task automatic push_token(logic [4:0] kind, logic [1:0] diag, bit at_post);
        res_t r;
        logic [31:0] eoff;
        eoff = at_post ? post_off : pre_off;
        if (step_results >= 4) return;
        r.kind = kind;
        r.diag = diag;
        r.sline = tok_line;
        r.scol = tok_col;
        r.eline = at_post ? post_line : pre_line;
        r.ecol = at_post ? post_col : pre_col;
        r.soff = tok_off;
        r.len = (eoff >= tok_off) ? ((eoff - tok_off > 32'hFFFF) ? 16'hFFFF : 16'(eoff - tok_off))
                                  : 16'd0;
        if (kind == K_NEWLINE) r.len = 16'd1;
        r.last = 1'b0;
        token_q = {token_q, r};
        step_results++;
    endtask

    task automatic lex_byte(logic [7:0] b);
        bit again;
        int pm;
        bit stay;
        logic [4:0] k;
        again = 1;
        while (again) begin
            again = 0;
            case (mode)
                M_IDLE:
                begin
                    if (!(b == " " || b == 8'h09 || b == 8'h0c || b == 8'h0b)) begin
                        mark_start();
                        if (eol_b(b)) begin
                            push_token(K_NEWLINE, D_NONE, 1);
                            if (b == 8'h0d) mode = M_CR;
                        end else if (alpha_b(b) || b == "_") mode = M_IDENT;
                        else if (b == "0") begin mode = M_ZERO; num_flags = 0; end
                        else if (digit_b(b)) begin mode = M_DEC; num_flags = 0; end
                        else if (b == 8'h22) mode = M_STR;
                        else if (b == 8'h27) mode = M_CHR;
                        else if (b == "/") mode = M_SLASH;
                        else if (opchar_b(b)) begin
                            mode = M_OP1;
                            held = {8'h00, b};
                            held_n = 1;
                        end else begin
                            k = mark_kind(b);
                            if (k != K_NONE) push_token(k, D_NONE, 1);
                            else push_token(K_INVALID, D_BYTE, 1);
                        end
                    end
                end
                M_CR:
                begin
                    mode = M_IDLE;
                    if (b != 8'h0a) again = 1;
                end
                M_SLASH:
                begin
                    if (b == "/") mode = M_LCMT;
                    else if (b == "*") mode = M_BCMT;
                    else begin
                        clear_state();
                        if (b == "=") push_token(K_OP, D_NONE, 1);
                        else begin push_token(K_OP, D_NONE, 0); again = 1; end
                    end
                end
                M_OP1:
                begin
                    pm = pair_kind(held[7:0], b);
                    if (pm == 1) begin
                        mode = M_OP2;
                        held[15:8] = b;
                        held_n = 2;
                    end else begin
                        clear_state();
                        if (pm == 2) push_token(K_OP, D_NONE, 1);
                        else begin push_token(K_OP, D_NONE, 0); again = 1; end
                    end
                end
                M_OP2:
                begin
                    clear_state();
                    if (b == "=") push_token(K_OP, D_NONE, 1);
                    else begin push_token(K_OP, D_NONE, 0); again = 1; end
                end
                M_LCMT:
                begin
                    if (eol_b(b)) begin mode = M_IDLE; again = 1; end
                end
                M_BCMT:
                begin
                    if (b == "*") mode = M_BSTAR;
                    else if (b == 8'h0d) mode = M_BCR;
                end
                M_BSTAR:
                begin
                    if (b == "/") clear_state();
                    else if (b != "*") begin mode = M_BCMT; again = 1; end
                end
                M_BCR:
                begin
                    mode = M_BCMT;
                    if (b != 8'h0a) again = 1;
                end
                M_IDENT:
                begin
                    if (!(alpha_b(b) || digit_b(b) || b == "_")) begin
                        clear_state();
                        push_token(K_IDENT, D_NONE, 0);
                        again = 1;
                    end
                end
                M_ZERO:
                begin
                    if (b == "x" || b == "X") mode = M_HEX;
                    else if (b == "o" || b == "O") mode = M_OCT;
                    else if (b == "b" || b == "B") mode = M_BIN;
                    else begin mode = M_DEC; again = 1; end
                end
                M_DEC, M_FRAC, M_EXPS, M_EXPD, M_HEX, M_OCT, M_BIN, M_SUFFIX:
                begin
                    stay = 0;
                    if (mode == M_DEC || mode == M_FRAC || mode == M_EXPD)
                        stay = digit_b(b) || b == "_";
                    else if (mode == M_HEX) stay = hex_b(b) || b == "_";
                    else if (mode == M_OCT) stay = (b >= "0" && b <= "7") || b == "_";
                    else if (mode == M_BIN) stay = b == "0" || b == "1" || b == "_";
                    if (!stay) begin
                        if (mode == M_DEC && b == ".") begin
                            mode = M_FRAC;
                            num_flags[0] = 1'b1;
                        end else if ((mode == M_DEC || mode == M_FRAC) && (b == "e" || b == "E"))
                        begin
                            mode = M_EXPS;
                            num_flags[0] = 1'b1;
                        end else if (mode == M_EXPS && (b == "+" || b == "-" || digit_b(b) ||
                                                         b == "_")) begin
                            mode = M_EXPD;
                        end else if (alpha_b(b)) begin
                            mode = M_SUFFIX;
                            if (b == "f" || b == "F") num_flags[0] = 1'b1;
                        end else begin
                            k = num_flags[0] ? K_FLOAT : K_INT;
                            clear_state();
                            push_token(k, D_NONE, 0);
                            again = 1;
                        end
                    end
                end
                M_STR, M_CHR:
                begin
                    if (b == 8'h5c) mode = (mode == M_STR) ? M_STRESC : M_CHRESC;
                    else if (b == ((mode == M_STR) ? 8'h22 : 8'h27)) begin
                        k = (mode == M_STR) ? K_STRING : K_CHAR;
                        clear_state();
                        push_token(k, D_NONE, 1);
                    end else if (eol_b(b)) begin
                        clear_state();
                        push_token(K_INVALID, D_LITERAL, 0);
                        again = 1;
                    end
                end
                M_STRESC, M_CHRESC:
                begin
                    if (eol_b(b)) begin
                        clear_state();
                        push_token(K_INVALID, D_LITERAL, 0);
                        again = 1;
                    end else mode = (mode == M_STRESC) ? M_STR : M_CHR;
                end
                default:
                begin
                    clear_state();
                    again = 1;
                end
            endcase
        end
    endtask

    task automatic predict_item(logic op, logic [7:0] b);
        step_results = 0;
        pre_line = cur_line;
        pre_col = cur_col;
        pre_off = cur_off;
        post_line = pre_line;
        post_col = pre_col;
        post_off = pre_off;
        if (op == OP_END) begin
            if (mode == M_SLASH || mode == M_OP1 || mode == M_OP2)
                push_token(K_OP, D_NONE, 0);
            else if (mode == M_BCMT || mode == M_BSTAR || mode == M_BCR)
                push_token(K_DIAG, D_COMMENT, 0);
            else if (mode == M_IDENT)
                push_token(K_IDENT, D_NONE, 0);
            else if (mode >= M_ZERO && mode <= M_SUFFIX)
                push_token(num_flags[0] ? K_FLOAT : K_INT, D_NONE, 0);
            else if (mode >= M_STR && mode <= M_CHRESC)
                push_token(K_INVALID, D_LITERAL, 0);
            mark_start();
            push_token(K_END, D_NONE, 0);
            clear_state();
            cur_line = 1;
            cur_col = 1;
            cur_off = 0;
            tok_line = 1;
            tok_col = 1;
            tok_off = 0;
        end else begin
            post_off = (pre_off == 32'hFFFFFFFF) ? pre_off : pre_off + 1;
            if (b == 8'h0a && (mode == M_CR || mode == M_BCR)) begin
            end else if (eol_b(b)) begin
                post_line = (pre_line == 20'hFFFFF) ? pre_line : pre_line + 1;
                post_col = 1;
            end else begin
                post_col = (pre_col == 16'hFFFF) ? pre_col : pre_col + 1;
            end
            lex_byte(b);
            cur_line = post_line;
            cur_col = post_col;
            cur_off = post_off;
        end
        if (step_results > 0) token_q[$].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n) begin
        res_t want;
        if (!rst_n) begin
            clear_state();
            cur_line = 1;
            cur_col = 1;
            cur_off = 0;
            tok_line = 1;
            tok_col = 1;
            tok_off = 0;
            token_q.delete();
            errors <= 0;
            pending <= 0;
            tokens_seen <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                tokens_seen <= tokens_seen + 1;
                if (token_q.size() == 0) begin
                    $error("unexpected token: kind %0d", m_tuser[4:0]);
                    errors <= errors + 1;
                end else begin
                    want = token_q.pop_front();
                    if (m_tuser[4:0] !== want.kind ||
                        m_tuser[6:5] !== want.diag ||
                        m_tdata[19:0] !== want.sline ||
                        m_tdata[35:20] !== want.scol ||
                        m_tdata[55:36] !== want.eline ||
                        m_tdata[71:56] !== want.ecol ||
                        m_tdata[103:72] !== want.soff ||
                        m_tdata[119:104] !== want.len ||
                        m_tlast !== want.last)
                        errors <= errors + 1;
                    if (m_tuser[4:0] !== want.kind)
                        $error("token_kind: expected %0d, got %0d", want.kind, m_tuser[4:0]);
                    if (m_tuser[6:5] !== want.diag)
                        $error("diag_code: expected %0d, got %0d", want.diag, m_tuser[6:5]);
                    if (m_tdata[19:0] !== want.sline)
                        $error("start_line: expected %0d, got %0d", want.sline, m_tdata[19:0]);
                    if (m_tdata[35:20] !== want.scol)
                        $error("start_column: expected %0d, got %0d", want.scol,
                               m_tdata[35:20]);
                    if (m_tdata[55:36] !== want.eline)
                        $error("end_line: expected %0d, got %0d", want.eline, m_tdata[55:36]);
                    if (m_tdata[71:56] !== want.ecol)
                        $error("end_column: expected %0d, got %0d", want.ecol, m_tdata[71:56]);
                    if (m_tdata[103:72] !== want.soff)
                        $error("start_offset: expected %0d, got %0d", want.soff,
                               m_tdata[103:72]);
                    if (m_tdata[119:104] !== want.len)
                        $error("lexeme_length: expected %0d, got %0d", want.len,
                               m_tdata[119:104]);
                    if (m_tlast !== want.last)
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
            pending <= token_q.size();
        end
    end

endmodule

@@ tb/tb_c_like_token_lexer.sv @@
`timescale 1ns / 1ps

module tb_c_like_token_lexer
    import clex_pkg::*;
;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic [6:0]   m_tuser;
    logic         m_tlast;
    int           errors;
    int           pending;
    int           tokens_seen;
    int           cycle_count;
    int           bytes_sent;
    int           ends_sent;

    string frags[] = '{
        "abc_1", "_Z9", "0x1F", "0XfF", "0o17", "0b101", "12_3", "09", "1.5e+3", "2.E7",
        "3f", "0x1f", "7u", "1.", "1e", "\"s\\n\"", "\"a\\\"b\"", "'a'", "'\\''", ">>=",
        "<<=", "->", "++", "--", "&&", "||", "<<", ">>", "==", "!=", "+", "%", "^", "/",
        "/=", "/*x*/", "/* a\015\n**/", "// c\n", "\015\n", "\n", "\015", " ", "\t",
        "\v", "\f", "(", ")", "{", "}", "[", "]", ",", ";", ":", "?", ".", "~", "@",
        "#", "\"open\n", "'q\015", "\"e\\\n", "*="
    };

    c_like_token_lexer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    c_like_token_lexer_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .errors      (errors),
        .pending     (pending),
        .tokens_seen (tokens_seen)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(logic op, logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (op == OP_END) ends_sent++;
        else bytes_sent++;
    endtask

    task automatic send_text(string t);
        for (int i = 0; i < t.len(); i++) send_item(OP_BYTE, t[i]);
    endtask

    initial
    begin
        int hold;
        m_tready = 1'b0;
        hold = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (cycle_count == 400) hold = 300;
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                hold = pick_gap();
                m_tready <= (hold == 0);
                if (hold > 0) hold--;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int r;
        int f;
        int waited;
        bytes_sent = 0;
        ends_sent = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = OP_BYTE;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unterminated literal, invalid bytes, then a flush
        send_text("x1 0xfF 1.e5\"a\n@");
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'h80);
        send_item(OP_BYTE, 8'hff);
        send_text("'b");
        send_item(OP_END, 8'h00);
        // open block comment at end of source
        send_text("/*\015\n*");
        send_item(OP_END, 8'h00);
        send_item(OP_END, 8'h00);

        while (bytes_sent + ends_sent < 460) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                f = $urandom_range(0, frags.size() - 1);
                send_text(frags[f]);
            end else if (r < 96) begin
                send_item(OP_BYTE, 8'($urandom_range(0, 255)));
            end else begin
                send_item(OP_END, 8'($urandom_range(0, 255)));
            end
        end
        send_item(OP_END, 8'h00);
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        waited = 0;
        while (waited < 20) begin
            @(posedge clk);
            waited++;
        end
        $display("sent %0d source bytes and %0d end-of-source items", bytes_sent, ends_sent);
        $display("checked %0d tokens over %0d cycles", tokens_seen, cycle_count);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
